// ----- hdl/vbnpm_pkg.sv -----
// Shared types and constants for the video bus nametable and palette map.
package vbnpm_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_NT_SIZE    = 1024;
    localparam int DEF_NT_BANKS   = 4;
    localparam int DEF_COLOR_BITS = 6;

    // Bus address decoding.
    localparam int          ADDR_BITS   = 14;
    localparam int          NT_OFF_BITS = 13;
    localparam logic [13:0] NT_BASE     = 14'h2000;
    localparam logic [13:0] PAL_BASE    = 14'h3F00;
    localparam int          PAL_OFF_BITS = 5;
    localparam int          PAL_COUNT   = 24;
    localparam int          BG_COUNT    = 4;

    // Access codes.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Configuration register indexes.
    localparam int          CFG_INDEX_BITS = 3;
    localparam int          SLOT_BITS      = 2;
    localparam int          SLOT_COUNT     = 4;
    localparam logic [2:0]  CFG_NT_SLOT_0  = 3'd0;
    localparam logic [2:0]  CFG_NT_SLOT_1  = 3'd1;
    localparam logic [2:0]  CFG_NT_SLOT_2  = 3'd2;
    localparam logic [2:0]  CFG_NT_SLOT_3  = 3'd3;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       unmapped;
    } t_out_item;

    // Request from the sequencer to the palette register file.
    typedef struct packed {
        logic                    we;
        logic                    re;
        logic [PAL_OFF_BITS-1:0] offset;
    } t_pal_req;

endpackage

// ----- hdl/video_bus_nametable_palette_map.sv -----
// Top level of the video bus nametable and palette map.
//
// This block decodes one video bus access per transfer and answers it from its own
// storage. The low 14 address bits are used. Addresses 0x2000-0x3EFF reach four
// logical nametables of NT_SIZE bytes, mirrored every 4*NT_SIZE bytes; each
// logical table is steered by its configuration slot to a physical bank of a
// single-port RAM of NT_BANKS*NT_SIZE bytes (a slot at or above NT_BANKS wraps).
// Addresses 0x3F00-0x3FFF reach the palette, mirrored every 32 bytes, where
// offsets with the low two bits clear share four background colors and the
// others select one of 24 entries; palette writes keep COLOR_BITS bits. A read
// returns the stored byte and also holds it as the open-bus value. Writes, and
// any access to the cartridge range 0x0000-0x1FFF, return the held value, and a
// cartridge access sets unmapped. Every access gives exactly one result transfer.
// After reset the block clears the nametable RAM, one byte per cycle, and keeps
// the input stalled until the cycle after that pass ends; configuration writes
// are taken at any time. Afterwards an item's result passes these registers in
// order: the transfer captures the item, the decode register folds the address
// into a table and row, the RAM or palette read register holds the access, and
// the output register is loaded last. The sequencer works on one item at a
// time, so a new item is taken only after the previous one has loaded the
// output register. The output register lets the next item be accepted while an
// earlier result waits; an item that reaches its last step while the output
// register is still full waits there, and the input stays stalled meanwhile.
module video_bus_nametable_palette_map #(
    parameter int NT_SIZE    = vbnpm_pkg::DEF_NT_SIZE,
    parameter int NT_BANKS   = vbnpm_pkg::DEF_NT_BANKS,
    parameter int COLOR_BITS = vbnpm_pkg::DEF_COLOR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vbnpm_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vbnpm_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_we,
    input  logic [vbnpm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [vbnpm_pkg::SLOT_BITS-1:0]     i_cfg_data
);
    import vbnpm_pkg::*;

    localparam int DEPTH    = NT_BANKS * NT_SIZE;
    localparam int AW       = $clog2(DEPTH);
    localparam int ROW_BITS = $clog2(NT_SIZE);
    localparam logic [SLOT_BITS-1:0] BANKS_S = SLOT_BITS'(NT_BANKS);
    localparam logic [AW-1:0]        SIZE_A  = AW'(NT_SIZE);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ACCESS,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RGN_CART,
        RGN_NT,
        RGN_PAL
    } t_region;

    t_state    r_state, n_state;
    t_region   r_region, n_region;
    t_in_item  r_item;
    t_out_item r_out, n_out;
    logic      r_out_valid, n_out_valid;
    logic [7:0] r_last, n_last;
    logic [SLOT_BITS-1:0] r_nt_slot [SLOT_COUNT];

    logic                  accept;
    logic                  out_free;
    logic [ADDR_BITS-1:0]  in_addr;
    logic [1:0]            logical;
    logic [ROW_BITS-1:0]   row;
    logic [SLOT_BITS-1:0]  slot;
    logic [SLOT_BITS-1:0]  bank;
    logic [AW-1:0]         ram_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [7:0]            ram_rdata;
    logic                  ram_busy;
    t_pal_req              pal_req;
    logic [COLOR_BITS-1:0] pal_rdata;

    // Input side: an item is taken only between accesses.
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;
    assign in_addr    = i_in_data.address[ADDR_BITS-1:0];

    always_comb begin
        if (in_addr < NT_BASE) begin
            n_region = RGN_CART;
        end else if (in_addr < PAL_BASE) begin
            n_region = RGN_NT;
        end else begin
            n_region = RGN_PAL;
        end
    end

    vbnpm_nt_decode #(
        .NT_SIZE (NT_SIZE)
    ) u_decode (
        .i_clk     (i_clk),
        .i_load    (r_state == S_DECODE),
        .i_addr    (r_item.address[ADDR_BITS-1:0]),
        .o_logical (logical),
        .o_row     (row)
    );

    // Physical bank for the logical table; slots never reach twice the bank count.
    assign slot     = r_nt_slot[logical];
    assign bank     = (slot >= BANKS_S) ? (slot - BANKS_S) : slot;
    assign ram_addr = AW'(bank) * SIZE_A + AW'(row);
    assign ram_we   = (r_state == S_ACCESS) && (r_region == RGN_NT)
                      && (r_item.action == ACT_WRITE);
    assign ram_re   = (r_state == S_ACCESS) && (r_region == RGN_NT)
                      && (r_item.action == ACT_READ);

    vbnpm_nt_ram #(
        .DEPTH (DEPTH)
    ) u_nt_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_item.write_data),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    always_comb begin
        pal_req.we     = (r_state == S_ACCESS) && (r_region == RGN_PAL)
                         && (r_item.action == ACT_WRITE);
        pal_req.re     = (r_state == S_ACCESS) && (r_region == RGN_PAL)
                         && (r_item.action == ACT_READ);
        pal_req.offset = r_item.address[PAL_OFF_BITS-1:0];
    end

    vbnpm_palette #(
        .COLOR_BITS (COLOR_BITS)
    ) u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pal_req),
        .i_wdata (r_item.write_data[COLOR_BITS-1:0]),
        .o_rdata (pal_rdata)
    );

    // Sequencer and output register.
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        case (r_state)
            S_CLEAR: begin
                if (!ram_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_ACCESS;
            end
            S_ACCESS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    // Reads of mapped storage refresh the open-bus value.
                    if (r_item.action == ACT_READ) begin
                        if (r_region == RGN_NT) begin
                            n_last = ram_rdata;
                        end else if (r_region == RGN_PAL) begin
                            n_last = 8'(pal_rdata);
                        end
                    end
                    n_out.read_data = n_last;
                    n_out.unmapped  = (r_region == RGN_CART);
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_last      <= 8'h00;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_item   <= i_in_data;
            r_region <= n_region;
        end
    end

    // Configuration slots; indexes past the last slot are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt_slot[0] <= SLOT_BITS'(0);
            r_nt_slot[1] <= SLOT_BITS'(1);
            r_nt_slot[2] <= SLOT_BITS'(0);
            r_nt_slot[3] <= SLOT_BITS'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NT_SLOT_0: r_nt_slot[0] <= i_cfg_data;
                CFG_NT_SLOT_1: r_nt_slot[1] <= i_cfg_data;
                CFG_NT_SLOT_2: r_nt_slot[2] <= i_cfg_data;
                CFG_NT_SLOT_3: r_nt_slot[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hdl/vbnpm_nt_decode.sv -----
// Nametable address decode: logical table and row offset, registered.
module vbnpm_nt_decode #(
    parameter int NT_SIZE = vbnpm_pkg::DEF_NT_SIZE
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic [vbnpm_pkg::ADDR_BITS-1:0]   i_addr,
    output logic [1:0]                        o_logical,
    output logic [$clog2(NT_SIZE)-1:0]        o_row
);
    import vbnpm_pkg::*;

    localparam int ROW_BITS = $clog2(NT_SIZE);
    localparam logic [NT_OFF_BITS-1:0] MIRROR = NT_OFF_BITS'(4 * NT_SIZE);
    localparam logic [NT_OFF_BITS-1:0] TABLE  = NT_OFF_BITS'(NT_SIZE);
    // Largest range offset divided by the mirror span: the number of folds
    // that can ever be needed.
    localparam int FOLDS = (int'(PAL_BASE) - int'(NT_BASE) - 1) / (4 * NT_SIZE);

    logic [1:0]          r_logical;
    logic [ROW_BITS-1:0] r_row;
    logic [1:0]          n_logical;
    logic [ROW_BITS-1:0] n_row;

    always_comb begin
        logic [NT_OFF_BITS-1:0] off;
        logic [1:0]             lg;
        off = NT_OFF_BITS'(i_addr - NT_BASE);
        lg  = 2'd0;
        // Only as many mirror folds as the range can hold are built.
        for (int i = 0; i < FOLDS; i++) begin
            if (off >= MIRROR) begin
                off = off - MIRROR;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (off >= TABLE) begin
                off = off - TABLE;
                lg  = lg + 2'd1;
            end
        end
        n_logical = lg;
        n_row     = off[ROW_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_logical <= n_logical;
            r_row     <= n_row;
        end
    end

    assign o_logical = r_logical;
    assign o_row     = r_row;

endmodule

// ----- hdl/vbnpm_nt_ram.sv -----
// Nametable storage: single-port synchronous RAM with a clearing pass after reset.
module vbnpm_nt_ram #(
    parameter int DEPTH = vbnpm_pkg::DEF_NT_SIZE * vbnpm_pkg::DEF_NT_BANKS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata,
    output logic                     o_busy
);
    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // During the clearing pass the sweep owns the write port.
    assign wr_en   = r_clearing | i_we;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_data = r_clearing ? 8'h00 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

// ----- hdl/vbnpm_palette.sv -----
// Palette storage: four background colors and 24 palette entries, registered read.
module vbnpm_palette #(
    parameter int COLOR_BITS = vbnpm_pkg::DEF_COLOR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vbnpm_pkg::t_pal_req   i_req,
    input  logic [COLOR_BITS-1:0] i_wdata,
    output logic [COLOR_BITS-1:0] o_rdata
);
    import vbnpm_pkg::*;

    logic [COLOR_BITS-1:0] r_bg  [BG_COUNT];
    logic [COLOR_BITS-1:0] r_ent [PAL_COUNT];
    logic [COLOR_BITS-1:0] r_rdata;
    logic [1:0]            lo;
    logic [2:0]            grp;
    logic                  is_bg;
    logic [4:0]            ent_idx;

    assign lo    = i_req.offset[1:0];
    assign grp   = i_req.offset[4:2];
    assign is_bg = (lo == 2'd0);
    // Three entries per group of four offsets; the result never reaches 24.
    assign ent_idx = 5'({2'b00, grp} * 5'd3) + {3'b000, lo} - 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BG_COUNT; i++) begin
                r_bg[i] <= '0;
            end
            for (int i = 0; i < PAL_COUNT; i++) begin
                r_ent[i] <= '0;
            end
        end else if (i_req.we) begin
            if (is_bg) begin
                r_bg[grp[1:0]] <= i_wdata;
            end else begin
                r_ent[ent_idx] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= is_bg ? r_bg[grp[1:0]] : r_ent[ent_idx];
        end
    end

    assign o_rdata = r_rdata;

endmodule
